// ----- src/jsr_pkg.sv -----
// Shared types and constants for the six-axis joint setpoint ramp.
// No dependencies; every other file of the block imports this package.
package jsr_pkg;

  localparam int NUM_AXES = 6;
  localparam int POS_W    = 24;
  localparam int STEP_W   = 21;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [STEP_W-1:0] step_t;

  // Axes whose goal resets to the negative value.
  localparam logic [NUM_AXES-1:0] GOAL_RST_NEG = 6'b001101;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_0    = 3'd0,
    REG_GOAL_1    = 3'd1,
    REG_GOAL_2    = 3'd2,
    REG_GOAL_3    = 3'd3,
    REG_GOAL_4    = 3'd4,
    REG_GOAL_5    = 3'd5,
    REG_BASE_STEP = 3'd6,
    REG_INIT_MEAS = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    pos_t [NUM_AXES-1:0] goal;
    step_t               base_step;
    logic                init_meas;
  } jsr_cfg_t;

endpackage

// ----- src/jsr_cfg.sv -----
// Configuration register file: joint goals, base step and the init flag.
// Depends on jsr_pkg.
module jsr_cfg #(
  parameter int POS_FRAC_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [jsr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jsr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output jsr_pkg::jsr_cfg_t            cfg_o
);
  import jsr_pkg::*;

  localparam longint ONE_L    = longint'(1) << POS_FRAC_BITS;
  localparam longint GOAL_L   = (3 * ONE_L + 5) / 10;
  localparam longint GOAL_SAT = (GOAL_L > 8388607) ? 8388607 : GOAL_L;
  localparam longint STEP_L   = (4 * ONE_L + 500) / 1000;
  localparam longint STEP_SAT = (STEP_L > 2097151) ? 2097151 : STEP_L;
  localparam pos_t   GOAL_POS = POS_W'(GOAL_SAT);
  localparam pos_t   GOAL_NEG = POS_W'(-GOAL_SAT);
  localparam step_t  STEP_RST = STEP_W'(STEP_SAT);

  pos_t [NUM_AXES-1:0] goal_q;
  step_t               base_step_q;
  logic                init_meas_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        goal_q[i] <= GOAL_RST_NEG[i] ? GOAL_NEG : GOAL_POS;
      end
      base_step_q <= STEP_RST;
      init_meas_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GOAL_0:    goal_q[0] <= pos_t'(cfg_data_i);
        REG_GOAL_1:    goal_q[1] <= pos_t'(cfg_data_i);
        REG_GOAL_2:    goal_q[2] <= pos_t'(cfg_data_i);
        REG_GOAL_3:    goal_q[3] <= pos_t'(cfg_data_i);
        REG_GOAL_4:    goal_q[4] <= pos_t'(cfg_data_i);
        REG_GOAL_5:    goal_q[5] <= pos_t'(cfg_data_i);
        REG_BASE_STEP: base_step_q <= cfg_data_i[STEP_W-1:0];
        REG_INIT_MEAS: init_meas_q <= cfg_data_i[0];
      endcase
    end
  end

  assign cfg_o.goal      = goal_q;
  assign cfg_o.base_step = base_step_q;
  assign cfg_o.init_meas = init_meas_q;

endmodule

// ----- src/jsr_joint.sv -----
// Per-joint ramp datapath: tolerance check, scaled step, goal limit, saturation.
// Depends on jsr_pkg.
module jsr_joint #(
  parameter int POS_FRAC_BITS = 20
) (
  input  jsr_pkg::pos_t  cmd_i,
  input  jsr_pkg::pos_t  goal_i,
  input  jsr_pkg::pos_t  meas_i,
  input  jsr_pkg::step_t base_step_i,
  output logic           moving_o,
  output jsr_pkg::pos_t  cmd_next_o,
  output jsr_pkg::pos_t  res_o
);
  import jsr_pkg::*;

  localparam int DIFF_W = POS_W + 1;
  localparam int TERM_W = ((POS_FRAC_BITS + 2 > DIFF_W) ? POS_FRAC_BITS + 2 : DIFF_W) + 1;
  localparam int PROD_W = TERM_W + STEP_W + 1;
  localparam int NC_W   = PROD_W + 1;
  localparam int TOL    = ((1 << POS_FRAC_BITS) + 500) / 1000;

  localparam logic signed [TERM_W-1:0] TWO_ONE = {{(TERM_W-1){1'b0}}, 1'b1} << (POS_FRAC_BITS + 1);
  localparam logic signed [PROD_W-1:0] HALF_LSB = {{(PROD_W-1){1'b0}}, 1'b1} << POS_FRAC_BITS;

  logic signed [DIFF_W-1:0] diff;
  logic        [DIFF_W-1:0] mag;
  logic signed [DIFF_W-1:0] err;
  logic signed [TERM_W-1:0] term;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] step;
  logic signed [PROD_W-1:0] room;
  logic signed [PROD_W-1:0] mv;
  logic signed [NC_W-1:0]   cmd_ext;
  logic signed [NC_W-1:0]   nc;

  always_comb begin
    diff = DIFF_W'(cmd_i) - DIFF_W'(goal_i);
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    moving_o = mag > DIFF_W'(TOL);

    // step = round_half_up(base_step * (2 + err) / 2), in position units.
    err  = DIFF_W'(meas_i) - DIFF_W'(cmd_i);
    term = TERM_W'(err) + TWO_ONE;
    prod = $signed({1'b0, base_step_i}) * term;
    rnd  = prod + HALF_LSB;
    step = rnd >>> (POS_FRAC_BITS + 1);

    // Never pass the goal.
    room = $signed(PROD_W'(mag));
    mv   = (step < room) ? step : room;

    cmd_ext = NC_W'(cmd_i);
    nc = diff[DIFF_W-1] ? (cmd_ext + NC_W'(mv)) : (cmd_ext - NC_W'(mv));

    if (nc[NC_W-1] && !(&nc[NC_W-1:POS_W-1])) begin
      cmd_next_o = {1'b1, {(POS_W-1){1'b0}}};
    end else if (!nc[NC_W-1] && (|nc[NC_W-1:POS_W-1])) begin
      cmd_next_o = {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      cmd_next_o = nc[POS_W-1:0];
    end

    res_o = moving_o ? cmd_next_o : goal_i;
  end

endmodule

// ----- src/joint_setpoint_ramp_six_axis_top.sv -----
// Six-axis rate-limited joint setpoint ramp, top level.
// An item is registered on acceptance; a tick's result is registered in the output register
// when the item advances; an untaken held result stalls the tick. Throughput: one item per
// cycle when not stalled; the joint datapath (one multiply per joint) runs once per cycle.
// Reset (asynchronous, active low) clears all positions, sets the first-sample flag and
// loads the default goals, base step and init flag; no clearing pass is needed.
module joint_setpoint_ramp_six_axis_top #(
  parameter int NUM_JOINTS    = 6,
  parameter int POS_FRAC_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [jsr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jsr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input item channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  jsr_pkg::pos_t                  meas_0_i,
  input  jsr_pkg::pos_t                  meas_1_i,
  input  jsr_pkg::pos_t                  meas_2_i,
  input  jsr_pkg::pos_t                  meas_3_i,
  input  jsr_pkg::pos_t                  meas_4_i,
  input  jsr_pkg::pos_t                  meas_5_i,
  // Result item channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output jsr_pkg::pos_t                  cmd_0_o,
  output jsr_pkg::pos_t                  cmd_1_o,
  output jsr_pkg::pos_t                  cmd_2_o,
  output jsr_pkg::pos_t                  cmd_3_o,
  output jsr_pkg::pos_t                  cmd_4_o,
  output jsr_pkg::pos_t                  cmd_5_o,
  output logic                           at_goal_o,
  output logic                           publish_o
);
  import jsr_pkg::*;

  // Joints beyond the configured count are held idle and report as reached.
  localparam int ACT = (NUM_JOINTS < NUM_AXES) ? NUM_JOINTS : NUM_AXES;

  jsr_cfg_t cfg;

  // Input register stage.
  logic                in_vld_q;
  op_e                 op_q;
  pos_t [NUM_AXES-1:0] meas_q;
  pos_t [NUM_AXES-1:0] meas_in;

  // Block state.
  pos_t meas_pos_q [ACT];
  pos_t cmd_pos_q  [ACT];
  logic first_pend_q;

  // Output register stage.
  logic                out_vld_q;
  pos_t [NUM_AXES-1:0] res_q;
  logic                reached_q;

  logic [NUM_AXES-1:0] moving;
  pos_t [NUM_AXES-1:0] res;
  pos_t                nxt [ACT];
  logic                adv;
  logic                load;
  logic                in_acc;

  jsr_cfg #(
    .POS_FRAC_BITS(POS_FRAC_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign meas_in = {meas_5_i, meas_4_i, meas_3_i, meas_2_i, meas_1_i, meas_0_i};

  // The registered item moves on when it is a sample (no result) or when the output
  // register is free or being emptied this cycle.
  assign adv    = in_vld_q && ((op_q == OP_SAMPLE) || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_acc = in_valid_i && in_ready_o;
  assign load   = first_pend_q && cfg.init_meas;

  for (genvar g = 0; g < NUM_AXES; g++) begin : gen_axis
    if (g < ACT) begin : gen_act
      jsr_joint #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
      ) u_joint (
        .cmd_i      (cmd_pos_q[g]),
        .goal_i     (cfg.goal[g]),
        .meas_i     (meas_pos_q[g]),
        .base_step_i(cfg.base_step),
        .moving_o   (moving[g]),
        .cmd_next_o (nxt[g]),
        .res_o      (res[g])
      );
    end else begin : gen_idle
      assign moving[g] = 1'b0;
      assign res[g]    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(operation_i);
      meas_q <= meas_in;
    end
  end

  // Samples update the measured positions (and the commands on the first loaded sample);
  // ticks commit the moved commands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ACT; i++) begin
        meas_pos_q[i] <= '0;
        cmd_pos_q[i]  <= '0;
      end
      first_pend_q <= 1'b1;
    end else if (adv) begin
      if (op_q == OP_SAMPLE) begin
        for (int i = 0; i < ACT; i++) begin
          meas_pos_q[i] <= meas_q[i];
          if (load) begin
            cmd_pos_q[i] <= meas_q[i];
          end
        end
        if (load) begin
          first_pend_q <= 1'b0;
        end
      end else begin
        for (int i = 0; i < ACT; i++) begin
          if (moving[i]) begin
            cmd_pos_q[i] <= nxt[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && (op_q == OP_TICK)) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && (op_q == OP_TICK)) begin
      res_q     <= res;
      reached_q <= ~|moving;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign cmd_0_o       = res_q[0];
  assign cmd_1_o       = res_q[1];
  assign cmd_2_o       = res_q[2];
  assign cmd_3_o       = res_q[3];
  assign cmd_4_o       = res_q[4];
  assign cmd_5_o       = res_q[5];
  assign at_goal_o     = reached_q;
  assign publish_o     = !reached_q;

`ifndef SYNTHESIS
  a_tick_makes_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (op_q == OP_TICK)) |=> out_valid_o)
    else $error("tick did not produce a result");

  a_sample_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (op_q == OP_SAMPLE) && !out_vld_q) |=> !out_valid_o)
    else $error("sample produced a result");

  a_load_clears_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (op_q == OP_SAMPLE) && first_pend_q && cfg.init_meas) |=> !first_pend_q)
    else $error("first sample did not clear the pending flag");

  a_pend_never_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_pend_q |=> !first_pend_q)
    else $error("pending flag set again after reset");

  a_stall_blocks_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && (op_q == OP_TICK) && out_vld_q && !out_ready_i) |-> !in_ready_o)
    else $error("tick accepted over a held result");
`endif

endmodule
